[hdl/irim_pkg.sv]
// Shared types, constants and register codes of the image rotate inverse map block.
// Depends on nothing; every module of the block imports it.
package irim_pkg;

    // Fixed field widths
    localparam int CRD_W      = 9;   // col, row and output size fields
    localparam int CFG_DIM_W  = 9;   // source_cols, source_rows registers
    localparam int COEF_W     = 16;  // cos_theta, sin_theta registers
    localparam int PIX_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int OUT_DIM_MAX = 511;

    // Parameter defaults
    localparam int DEF_MAX_COLS       = 256;
    localparam int DEF_MAX_ROWS       = 256;
    localparam int DEF_COEF_FRAC_BITS = 14;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COS_THETA   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_THETA   = 2'd3;

    // Register reset values
    localparam logic [CFG_DIM_W-1:0] RST_SOURCE_COLS = 9'd256;
    localparam logic [CFG_DIM_W-1:0] RST_SOURCE_ROWS = 9'd256;
    localparam logic signed [COEF_W-1:0] RST_COS_THETA = 16'sd16384;
    localparam logic signed [COEF_W-1:0] RST_SIN_THETA = 16'sd0;

    // Request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Geometry pipeline settle time after a register write
    localparam int GEO_CNT_W = 3;
    localparam logic [GEO_CNT_W-1:0] GEO_LAT = 3'd7;

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic signed [COEF_W-1:0] cos_v;
        logic signed [COEF_W-1:0] sin_v;
    } coef_t;

    typedef struct packed {
        logic [CRD_W-1:0] cols;
        logic [CRD_W-1:0] rows;
    } dims_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             outside;
    } out_beat_t;

endpackage

[hdl/irim_frame_store.sv]
// Single-port frame store: one write or one registered read per cycle.
// Depends on irim_pkg for the pixel width.
module irim_frame_store #(
    parameter int DEPTH  = irim_pkg::DEF_MAX_COLS * irim_pkg::DEF_MAX_ROWS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       mem_en,
    input  logic                       mem_we,
    input  logic [ADDR_W-1:0]          mem_addr,
    input  logic [irim_pkg::PIX_W-1:0] mem_wdata,
    output logic [irim_pkg::PIX_W-1:0] mem_rdata
);
    import irim_pkg::*;

    logic [PIX_W-1:0] store_arr [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_en) begin
            if (mem_we) begin
                store_arr[mem_addr] <= mem_wdata;
            end else begin
                rdata_reg <= store_arr[mem_addr];
            end
        end
    end

    assign mem_rdata = rdata_reg;

endmodule

[hdl/irim_geometry.sv]
// Configuration registers and the pipelined bounding-box / output-size computation.
// Depends on irim_pkg for field widths, register codes and shared types.
module irim_geometry #(
    parameter int MAX_COLS       = irim_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS       = irim_pkg::DEF_MAX_ROWS,
    parameter int COEF_FRAC_BITS = irim_pkg::DEF_COEF_FRAC_BITS,
    parameter int DIM_W          = 9,
    parameter int OFF_W          = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [irim_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [irim_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic                            geo_ready,
    output logic [DIM_W-1:0]                c_dim,
    output logic [DIM_W-1:0]                r_dim,
    output irim_pkg::coef_t                 coef,
    output logic signed [OFF_W-1:0]         nx,
    output logic signed [OFF_W-1:0]         ny,
    output irim_pkg::dims_t                 out_size
);
    import irim_pkg::*;

    localparam int PROD_W = DIM_W + 1 + COEF_W;
    localparam int GEO_W  = PROD_W + 3;
    localparam int CMP_W  = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
    localparam int HALF_I = 2 ** (COEF_FRAC_BITS - 1);
    localparam logic [CMP_W-1:0] MAX_COLS_C = CMP_W'(MAX_COLS);
    localparam logic [CMP_W-1:0] MAX_ROWS_C = CMP_W'(MAX_ROWS);
    localparam logic signed [GEO_W-1:0] HALF_G = GEO_W'(HALF_I);
    localparam logic signed [GEO_W-1:0] ZERO_G = '0;
    localparam logic signed [GEO_W-1:0] ONE_G  = GEO_W'(1);
    localparam logic signed [GEO_W-1:0] DMAX_G = GEO_W'(OUT_DIM_MAX);
    localparam logic [COEF_FRAC_BITS-1:0] HALF_F = COEF_FRAC_BITS'(HALF_I);

    function automatic logic signed [GEO_W-1:0] min4(
        input logic signed [GEO_W-1:0] a, input logic signed [GEO_W-1:0] b,
        input logic signed [GEO_W-1:0] c, input logic signed [GEO_W-1:0] d);
        logic signed [GEO_W-1:0] m;
        m = a;
        if (b < m) m = b;
        if (c < m) m = c;
        if (d < m) m = d;
        return m;
    endfunction

    function automatic logic signed [GEO_W-1:0] max4(
        input logic signed [GEO_W-1:0] a, input logic signed [GEO_W-1:0] b,
        input logic signed [GEO_W-1:0] c, input logic signed [GEO_W-1:0] d);
        logic signed [GEO_W-1:0] m;
        m = a;
        if (b > m) m = b;
        if (c > m) m = c;
        if (d > m) m = d;
        return m;
    endfunction

    // Round to nearest, ties to even
    function automatic logic signed [GEO_W-1:0] rnd_even(input logic signed [GEO_W-1:0] v);
        logic signed [GEO_W-1:0] fl;
        logic [COEF_FRAC_BITS-1:0] fr;
        fl = v >>> COEF_FRAC_BITS;
        fr = v[COEF_FRAC_BITS-1:0];
        if (fr > HALF_F) return fl + ONE_G;
        if (fr == HALF_F && fl[0]) return fl + ONE_G;
        return fl;
    endfunction

    function automatic logic [CRD_W-1:0] clamp_dim(input logic signed [GEO_W-1:0] r);
        logic signed [GEO_W-1:0] w;
        w = r + ONE_G;
        if (w < ONE_G) return CRD_W'(1);
        if (w > DMAX_G) return CRD_W'(OUT_DIM_MAX);
        return w[CRD_W-1:0];
    endfunction

    // Configuration registers
    logic [CFG_DIM_W-1:0]     src_cols_reg, src_rows_reg;
    logic signed [COEF_W-1:0] cos_reg, sin_reg;
    logic [GEO_CNT_W-1:0]     stale_cnt_reg, stale_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_cols_reg <= RST_SOURCE_COLS;
            src_rows_reg <= RST_SOURCE_ROWS;
            cos_reg      <= RST_COS_THETA;
            sin_reg      <= RST_SIN_THETA;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SOURCE_COLS: src_cols_reg <= cfg_wdata[CFG_DIM_W-1:0];
                REG_SOURCE_ROWS: src_rows_reg <= cfg_wdata[CFG_DIM_W-1:0];
                REG_COS_THETA:   cos_reg <= $signed(cfg_wdata[COEF_W-1:0]);
                REG_SIN_THETA:   sin_reg <= $signed(cfg_wdata[COEF_W-1:0]);
                default: ;
            endcase
        end
    end

    // Hold off items until the new geometry has flushed through
    always_comb begin
        stale_cnt_next = stale_cnt_reg;
        if (cfg_wr_en) begin
            stale_cnt_next = GEO_LAT;
        end else if (stale_cnt_reg != '0) begin
            stale_cnt_next = stale_cnt_reg - GEO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stale_cnt_reg <= GEO_LAT;
        end else begin
            stale_cnt_reg <= stale_cnt_next;
        end
    end

    assign geo_ready = (stale_cnt_reg == '0);

    // Stage 1: effective source size
    logic [CMP_W-1:0] cols_cmp, rows_cmp;
    logic [DIM_W-1:0] c_dim_next, r_dim_next, c_dim_reg, r_dim_reg;
    coef_t            coef_reg;

    always_comb begin
        cols_cmp = CMP_W'(src_cols_reg);
        rows_cmp = CMP_W'(src_rows_reg);
        if (src_cols_reg == '0) c_dim_next = DIM_W'(1);
        else if (cols_cmp > MAX_COLS_C) c_dim_next = DIM_W'(MAX_COLS);
        else c_dim_next = DIM_W'(cols_cmp);
        if (src_rows_reg == '0) r_dim_next = DIM_W'(1);
        else if (rows_cmp > MAX_ROWS_C) r_dim_next = DIM_W'(MAX_ROWS);
        else r_dim_next = DIM_W'(rows_cmp);
    end

    always_ff @(posedge aclk) begin
        c_dim_reg      <= c_dim_next;
        r_dim_reg      <= r_dim_next;
        coef_reg.cos_v <= cos_reg;
        coef_reg.sin_v <= sin_reg;
    end

    // Stage 2: corner products
    logic signed [PROD_W-1:0] c_ext, r_ext, cos_ext, sin_ext;
    logic signed [PROD_W-1:0] cc_next, cs_next, rc_next, rs_next;
    logic signed [PROD_W-1:0] cc_reg, cs_reg, rc_reg, rs_reg;

    always_comb begin
        c_ext   = PROD_W'($signed({1'b0, c_dim_reg}));
        r_ext   = PROD_W'($signed({1'b0, r_dim_reg}));
        cos_ext = PROD_W'(coef_reg.cos_v);
        sin_ext = PROD_W'(coef_reg.sin_v);
        cc_next = c_ext * cos_ext;
        cs_next = c_ext * sin_ext;
        rc_next = r_ext * cos_ext;
        rs_next = r_ext * sin_ext;
    end

    always_ff @(posedge aclk) begin
        cc_reg <= cc_next;
        cs_reg <= cs_next;
        rc_reg <= rc_next;
        rs_reg <= rs_next;
    end

    // Stage 3: rotated corners
    logic signed [GEO_W-1:0] x0_next, x1_next, x2_next, y0_next, y1_next, y2_next;
    logic signed [GEO_W-1:0] x0_reg, x1_reg, x2_reg, y0_reg, y1_reg, y2_reg;

    always_comb begin
        x0_next = GEO_W'(rs_reg);
        x1_next = GEO_W'(cc_reg) + GEO_W'(rs_reg);
        x2_next = GEO_W'(cc_reg);
        y0_next = GEO_W'(rc_reg);
        y1_next = GEO_W'(rc_reg) - GEO_W'(cs_reg);
        y2_next = ZERO_G - GEO_W'(cs_reg);
    end

    always_ff @(posedge aclk) begin
        x0_reg <= x0_next;
        x1_reg <= x1_next;
        x2_reg <= x2_next;
        y0_reg <= y0_next;
        y1_reg <= y1_next;
        y2_reg <= y2_next;
    end

    // Stage 4: bounding box
    logic signed [GEO_W-1:0] minx_reg, maxx_reg, miny_reg, maxy_reg;
    logic signed [GEO_W-1:0] minx_next, maxx_next, miny_next, maxy_next;

    always_comb begin
        minx_next = min4(x0_reg, x1_reg, x2_reg, ZERO_G);
        maxx_next = max4(x0_reg, x1_reg, x2_reg, ZERO_G);
        miny_next = min4(y0_reg, y1_reg, y2_reg, ZERO_G);
        maxy_next = max4(y0_reg, y1_reg, y2_reg, ZERO_G);
    end

    always_ff @(posedge aclk) begin
        minx_reg <= minx_next;
        maxx_reg <= maxx_next;
        miny_reg <= miny_next;
        maxy_reg <= maxy_next;
    end

    // Stage 5: spans and offsets before rounding
    logic signed [GEO_W-1:0] spanx_next, spany_next, offx_next, offy_next;
    logic signed [GEO_W-1:0] spanx_reg, spany_reg, offx_reg, offy_reg;

    always_comb begin
        spanx_next = maxx_reg - minx_reg + HALF_G;
        spany_next = maxy_reg - miny_reg + HALF_G;
        offx_next  = minx_reg + HALF_G;
        offy_next  = miny_reg + HALF_G;
    end

    always_ff @(posedge aclk) begin
        spanx_reg <= spanx_next;
        spany_reg <= spany_next;
        offx_reg  <= offx_next;
        offy_reg  <= offy_next;
    end

    // Stage 6: round, clamp
    dims_t                   size_next, size_reg;
    logic signed [OFF_W-1:0] nx_next, ny_next, nx_reg, ny_reg;

    always_comb begin
        size_next.cols = clamp_dim(rnd_even(spanx_reg));
        size_next.rows = clamp_dim(rnd_even(spany_reg));
        nx_next        = OFF_W'(rnd_even(offx_reg));
        ny_next        = OFF_W'(rnd_even(offy_reg));
    end

    always_ff @(posedge aclk) begin
        size_reg <= size_next;
        nx_reg   <= nx_next;
        ny_reg   <= ny_next;
    end

    assign c_dim    = c_dim_reg;
    assign r_dim    = r_dim_reg;
    assign coef     = coef_reg;
    assign nx       = nx_reg;
    assign ny       = ny_reg;
    assign out_size = size_reg;

endmodule

[hdl/irim_map.sv]
// Per-item pipeline: inverse mapping of output pixels, frame store access, result forming.
// Depends on irim_pkg for widths, request codes and shared types.
module irim_map #(
    parameter int MAX_COLS       = irim_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS       = irim_pkg::DEF_MAX_ROWS,
    parameter int COEF_FRAC_BITS = irim_pkg::DEF_COEF_FRAC_BITS,
    parameter int DIM_W          = 9,
    parameter int OFF_W          = 16,
    parameter int ADDR_W         = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_vld,
    input  logic                       in_type,
    input  logic [irim_pkg::CRD_W-1:0] in_col,
    input  logic [irim_pkg::CRD_W-1:0] in_row,
    input  logic [irim_pkg::PIX_W-1:0] in_pix,
    input  logic [DIM_W-1:0]           c_dim,
    input  logic [DIM_W-1:0]           r_dim,
    input  irim_pkg::coef_t            coef,
    input  logic signed [OFF_W-1:0]    nx,
    input  logic signed [OFF_W-1:0]    ny,
    output logic                       mem_en,
    output logic                       mem_we,
    output logic [ADDR_W-1:0]          mem_addr,
    output logic [irim_pkg::PIX_W-1:0] mem_wdata,
    input  logic [irim_pkg::PIX_W-1:0] mem_rdata,
    output logic                       res_push,
    output irim_pkg::out_beat_t        res_beat
);
    import irim_pkg::*;

    localparam int U_W   = ((OFF_W > CRD_W) ? OFF_W : CRD_W) + 2;
    localparam int MUL_W = U_W + COEF_W;
    localparam int SUM_W = MUL_W + 1;
    localparam int LIM_W = (DIM_W > CRD_W) ? DIM_W : CRD_W;
    localparam logic signed [SUM_W-1:0] BIAS   = SUM_W'(2 ** COEF_FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] ZERO_S = '0;
    localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(MAX_COLS);
    localparam logic [LIM_W-1:0]  COLS_L = LIM_W'(MAX_COLS);
    localparam logic [LIM_W-1:0]  ROWS_L = LIM_W'(MAX_ROWS);

    // Stage A: output pixel plus offset
    logic                    a_vld_reg, a_read_reg;
    logic [CRD_W-1:0]        a_col_reg, a_row_reg;
    logic [PIX_W-1:0]        a_pix_reg;
    logic signed [U_W-1:0]   a_u_reg, a_v_reg, a_u_next, a_v_next;

    always_comb begin
        a_u_next = U_W'($signed({1'b0, in_col})) + U_W'(nx);
        a_v_next = U_W'($signed({1'b0, in_row})) + U_W'(ny);
    end

    always_ff @(posedge aclk) begin
        a_read_reg <= (in_type == REQ_READ);
        a_col_reg  <= in_col;
        a_row_reg  <= in_row;
        a_pix_reg  <= in_pix;
        a_u_reg    <= a_u_next;
        a_v_reg    <= a_v_next;
    end

    // Stage B: rotation products
    logic                    b_vld_reg, b_read_reg;
    logic [CRD_W-1:0]        b_col_reg, b_row_reg;
    logic [PIX_W-1:0]        b_pix_reg;
    logic signed [MUL_W-1:0] u_ext, v_ext, cos_ext, sin_ext;
    logic signed [MUL_W-1:0] uc_next, vs_next, us_next, vc_next;
    logic signed [MUL_W-1:0] uc_reg, vs_reg, us_reg, vc_reg;

    always_comb begin
        u_ext   = MUL_W'(a_u_reg);
        v_ext   = MUL_W'(a_v_reg);
        cos_ext = MUL_W'(coef.cos_v);
        sin_ext = MUL_W'(coef.sin_v);
        uc_next = u_ext * cos_ext;
        vs_next = v_ext * sin_ext;
        us_next = u_ext * sin_ext;
        vc_next = v_ext * cos_ext;
    end

    always_ff @(posedge aclk) begin
        b_read_reg <= a_read_reg;
        b_col_reg  <= a_col_reg;
        b_row_reg  <= a_row_reg;
        b_pix_reg  <= a_pix_reg;
        uc_reg     <= uc_next;
        vs_reg     <= vs_next;
        us_reg     <= us_next;
        vc_reg     <= vc_next;
    end

    // Stage C: source point sums, then truncate, range check and address the store
    logic                    c_vld_reg, c_read_reg;
    logic [CRD_W-1:0]        c_col_reg, c_row_reg;
    logic [PIX_W-1:0]        c_pix_reg;
    logic signed [SUM_W-1:0] sx_next, sy_next, sx_reg, sy_reg;
    logic signed [SUM_W-1:0] sx_bias, sy_bias, sx_t, sy_t, c_lim, r_lim;
    logic                    src_hit, load_ok;

    always_comb begin
        sx_next = SUM_W'(uc_reg) - SUM_W'(vs_reg);
        sy_next = SUM_W'(us_reg) + SUM_W'(vc_reg);
    end

    always_ff @(posedge aclk) begin
        c_read_reg <= b_read_reg;
        c_col_reg  <= b_col_reg;
        c_row_reg  <= b_row_reg;
        c_pix_reg  <= b_pix_reg;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
    end

    always_comb begin
        // Truncate toward zero: bias negative values before the arithmetic shift
        sx_bias = sx_reg[SUM_W-1] ? BIAS : ZERO_S;
        sy_bias = sy_reg[SUM_W-1] ? BIAS : ZERO_S;
        sx_t    = (sx_reg + sx_bias) >>> COEF_FRAC_BITS;
        sy_t    = (sy_reg + sy_bias) >>> COEF_FRAC_BITS;
        c_lim   = SUM_W'($signed({1'b0, c_dim}));
        r_lim   = SUM_W'($signed({1'b0, r_dim}));
        src_hit = !sx_t[SUM_W-1] && (sx_t < c_lim) && !sy_t[SUM_W-1] && (sy_t < r_lim);
        load_ok = (LIM_W'(c_col_reg) < COLS_L) && (LIM_W'(c_row_reg) < ROWS_L);

        mem_we    = !c_read_reg;
        mem_en    = c_vld_reg && (c_read_reg ? src_hit : load_ok);
        mem_wdata = c_pix_reg;
        if (c_read_reg) begin
            mem_addr = $unsigned(ADDR_W'(sy_t)) * COLS_A + $unsigned(ADDR_W'(sx_t));
        end else begin
            mem_addr = ADDR_W'(c_row_reg) * COLS_A + ADDR_W'(c_col_reg);
        end
    end

    // Stage D: read data returns; zero the pixel when outside
    logic d_vld_reg, d_outside_reg;

    always_ff @(posedge aclk) begin
        d_outside_reg <= !src_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg && c_read_reg;
        end
    end

    assign res_push         = d_vld_reg;
    assign res_beat.pixel   = d_outside_reg ? '0 : mem_rdata;
    assign res_beat.outside = d_outside_reg;

endmodule

[hdl/irim_out_fifo.sv]
// Small result queue that decouples the mapping pipeline from the result channel.
// Depends on irim_pkg for the queue depth and the result beat type.
module irim_out_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  irim_pkg::out_beat_t push_beat,
    input  logic                pop,
    output logic                not_empty,
    output irim_pkg::out_beat_t head_beat
);
    import irim_pkg::*;

    out_beat_t              fifo_arr [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_arr[wr_ptr_reg] <= push_beat;
        end
    end

    always_comb begin
        cnt_next = cnt_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    assign not_empty = (cnt_reg != '0);
    assign head_beat = fifo_arr[rd_ptr_reg];

endmodule

[hdl/image_rotate_inverse_map.sv]
// Top level of the image rotate inverse map block: ports, credit control, assertions.
// Depends on irim_pkg, irim_geometry, irim_map, irim_frame_store and irim_out_fifo.
//
// Usage:
//   Input channel (s_*): each beat is either a load (s_req_type = 0), which writes
//   s_pixel_in into the frame store at (s_col, s_row), or a read (s_req_type = 1),
//   which names an output pixel. Loads give no result; each read gives one result
//   beat on the m_* channel: the source pixel found by inverse rotation
//   (truncated toward zero), or zero with m_outside set, plus the output image size.
//   Configuration (cfg_*): write source size and Q-format cos/sin while idle; the
//   geometry pipeline then settles, and s_ready stays low meanwhile.
//   Throughput: one beat per cycle while s_ready is high, limited by the single-port
//   frame store, which serves one load or one read in each cycle.
//   Path: an accepted read passes map stages A, B, C and D and is then pushed into
//   the result queue; m_valid rises in the following cycle.
//   Stall: an 8-entry result queue absorbs back-pressure. A credit counter of reads
//   in flight plus queued drops s_ready once 8 are outstanding, so no result is lost.
//   Reset: synchronous, active low. Registers return to 256 x 256, cos = 1.0,
//   sin = 0; the frame store holds garbage until loaded and is not cleared.
module image_rotate_inverse_map #(
    parameter int MAX_COLS       = irim_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS       = irim_pkg::DEF_MAX_ROWS,
    parameter int COEF_FRAC_BITS = irim_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_req_type,
    input  logic [irim_pkg::CRD_W-1:0]      s_col,
    input  logic [irim_pkg::CRD_W-1:0]      s_row,
    input  logic [irim_pkg::PIX_W-1:0]      s_pixel_in,
    // Result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [irim_pkg::PIX_W-1:0]      m_pixel_out,
    output logic                            m_outside,
    output logic [irim_pkg::CRD_W-1:0]      m_out_cols,
    output logic [irim_pkg::CRD_W-1:0]      m_out_rows,
    // Configuration write port
    input  logic                            cfg_wr_en,
    input  logic [irim_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [irim_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import irim_pkg::*;

    localparam int MAX_DIM = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int PROD_W  = DIM_W + 1 + COEF_W;
    localparam int GEO_W   = PROD_W + 3;
    localparam int OFF_W   = GEO_W - COEF_FRAC_BITS + 1;
    localparam int DEPTH   = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W  = $clog2(DEPTH);

    // Geometry derived from the configuration registers
    logic                    geo_ready;
    logic [DIM_W-1:0]        c_dim, r_dim;
    coef_t                   coef;
    logic signed [OFF_W-1:0] nx, ny;
    dims_t                   out_size;

    irim_geometry #(
        .MAX_COLS       (MAX_COLS),
        .MAX_ROWS       (MAX_ROWS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .DIM_W          (DIM_W),
        .OFF_W          (OFF_W)
    ) u_geometry (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .geo_ready (geo_ready),
        .c_dim     (c_dim),
        .r_dim     (r_dim),
        .coef      (coef),
        .nx        (nx),
        .ny        (ny),
        .out_size  (out_size)
    );

    // Credit: reads accepted whose result beat has not yet left
    logic                  s_accept, rd_accept, m_pop;
    logic [FIFO_CNT_W-1:0] pend_cnt_reg, pend_cnt_next;

    assign s_ready   = geo_ready && (pend_cnt_reg < FIFO_CNT_W'(FIFO_DEPTH));
    assign s_accept  = s_valid && s_ready;
    assign rd_accept = s_accept && (s_req_type == REQ_READ);
    assign m_pop     = m_valid && m_ready;

    always_comb begin
        pend_cnt_next = pend_cnt_reg + FIFO_CNT_W'(rd_accept) - FIFO_CNT_W'(m_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_cnt_reg <= '0;
        end else begin
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    // Mapping pipeline and frame store
    logic             mem_en, mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [PIX_W-1:0] mem_wdata, mem_rdata;
    logic             res_push;
    out_beat_t        res_beat, head_beat;

    irim_map #(
        .MAX_COLS       (MAX_COLS),
        .MAX_ROWS       (MAX_ROWS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .DIM_W          (DIM_W),
        .OFF_W          (OFF_W),
        .ADDR_W         (ADDR_W)
    ) u_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_vld    (s_accept),
        .in_type   (s_req_type),
        .in_col    (s_col),
        .in_row    (s_row),
        .in_pix    (s_pixel_in),
        .c_dim     (c_dim),
        .r_dim     (r_dim),
        .coef      (coef),
        .nx        (nx),
        .ny        (ny),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .res_push  (res_push),
        .res_beat  (res_beat)
    );

    irim_frame_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_frame_store (
        .aclk      (aclk),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    // Result queue; drain on the m_* handshake
    irim_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_beat (res_beat),
        .pop       (m_pop),
        .not_empty (m_valid),
        .head_beat (head_beat)
    );

    assign m_pixel_out = head_beat.pixel;
    assign m_outside   = head_beat.outside;
    // User must keep output size static while results are pending; not enforced
    assign m_out_cols  = out_size.cols;
    assign m_out_rows  = out_size.rows;

    // A register write must hold off input beats while the geometry settles
    a_cfg_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_ready)
        else $error("input accepted right after a configuration write");

    // Outstanding reads never exceed the result queue depth
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("outstanding read count exceeds result queue depth");

    // A result beat on offer must belong to an outstanding read
    a_result_has_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pend_cnt_reg != '0))
        else $error("result beat without an outstanding read");

    // A result is pushed only when its read holds credit
    a_push_has_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> (pend_cnt_reg != '0))
        else $error("result pushed without an outstanding read");

endmodule
